### hdl/tdm_pkg.sv
// Package for the trie dictionary matcher.
// Holds the beat payload structs, command and status codes, and sizing constants.
// No dependencies.
package tdm_pkg;

  localparam int NODES_DEFAULT = 1024;
  localparam int SYMBOL_BITS   = 8;
  localparam int TAG_BITS      = 16;
  localparam int COUNT_BITS    = 11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_EXACT  = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_DUP  = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]             cmd;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   no_symbol;
    logic                   last;
    logic [TAG_BITS-1:0]    tag;
  } in_beat_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]   match_tag;
    logic [2:0]            status;
    logic [COUNT_BITS-1:0] stored_patterns;
  } out_beat_t;

endpackage

### hdl/tdm_edge_mem.sv
// Edge store of the trie: per node its parent node and incoming label.
// Depends on tdm_pkg for the symbol width.
module tdm_edge_mem import tdm_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(NODES)-1:0]             waddr,
  input  logic [$clog2(NODES)+SYMBOL_BITS-1:0] wdata,
  input  logic                                 re,
  input  logic [$clog2(NODES)-1:0]             raddr,
  output logic [$clog2(NODES)+SYMBOL_BITS-1:0] rdata
);

  localparam int W = $clog2(NODES) + SYMBOL_BITS;

  logic [W-1:0] mem [NODES];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tdm_tag_mem.sv
// Tag store of the trie: one tag per node, the root tag kept in a register.
// Depends on tdm_pkg for the tag width; other entries are written at node creation.
module tdm_tag_mem import tdm_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(NODES)-1:0] waddr,
  input  logic [TAG_BITS-1:0]      wdata,
  input  logic                     re,
  input  logic [$clog2(NODES)-1:0] raddr,
  output logic [TAG_BITS-1:0]      rdata
);

  logic [TAG_BITS-1:0] mem [NODES];
  logic [TAG_BITS-1:0] mem_q;
  logic [TAG_BITS-1:0] root_tag;
  logic                root_sel;

  // Array entries; node zero never lands here.
  always_ff @(posedge clk) begin
    if (we && (waddr != '0)) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q    <= mem[raddr];
      root_sel <= (raddr == '0);
    end
  end

  // The root tag must read as zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      root_tag <= '0;
    end else if (we && (waddr == '0)) begin
      root_tag <= wdata;
    end
  end

  assign rdata = root_sel ? root_tag : mem_q;

endmodule

### hdl/trie_dictionary_matcher_top.sv
// Top level of the trie dictionary matcher: command sequencer and output register.
// Depends on tdm_pkg, tdm_edge_mem and tdm_tag_mem.
//
// Usage: bytes arrive on the in channel (in_valid / in_stall / in_data) with a
// command: insert, exact walk, search or cursor reset. Results leave on the out
// channel (out_valid / out_stall / out_data), at most one per input beat.
// One beat is worked on at a time; in_stall is high while it is in progress.
// A byte that needs an edge lookup scans the edge store linearly, one read and
// one compare per stored node, so its time grows with the node count; the edge
// memory's single read port sets this. A finished result waits in the output
// register while the next beat is accepted; if the receiver still stalls when
// the following result is ready, the sequencer holds until the register frees.
// Reset (synchronous, active high) leaves only the root node, no patterns, both
// cursors at the root and the output empty. The tag store needs no clearing
// pass: every node's tag is written when the node is created.
module trie_dictionary_matcher_top import tdm_pkg::*; #(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int NB = $clog2(NODES);
  localparam int CB = NB + 1;
  localparam int EW = NB + SYMBOL_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_POST  = 3'd4;
  localparam logic [2:0] S_ILAST = 3'd5;
  localparam logic [2:0] S_TUSE  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]          state;
  in_beat_t            item;
  logic [NB-1:0]       walk_cursor;
  logic [NB-1:0]       insert_cursor;
  logic                skip_rest;
  logic [1:0]          insert_fault;
  logic [CB-1:0]       node_total;
  logic [COUNT_BITS-1:0] pattern_total;
  logic [CB-1:0]       scan_n;
  logic [NB-1:0]       scan_parent;
  logic                scan_found;
  logic [NB-1:0]       scan_node;
  logic [NB-1:0]       tag_addr;
  logic [TAG_BITS-1:0] emit_tag;
  logic [2:0]          emit_status;

  logic                edge_we;
  logic [EW-1:0]       edge_rdata;
  logic                edge_re;
  logic                tag_we;
  logic [NB-1:0]       tag_waddr;
  logic [TAG_BITS-1:0] tag_wdata;
  logic                tag_re;
  logic [TAG_BITS-1:0] tag_rdata;
  logic [1:0]          fault_new;

  assign in_stall  = (state != S_IDLE);
  assign edge_re   = (state == S_SCAN) && (scan_n < node_total);
  assign edge_we   = (state == S_POST) && (item.cmd == CMD_INSERT) && !scan_found &&
                     (node_total < CB'(NODES));
  assign tag_re    = (state == S_ILAST) || ((state == S_DISP) && (item.cmd != CMD_INSERT));
  assign fault_new = ((insert_fault == FAULT_NONE) && (item.tag == '0)) ? FAULT_ZERO
                                                                        : insert_fault;

  // Tag writes: zero for a new node, the pattern tag on a fresh insert.
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = node_total[NB-1:0];
    tag_wdata = '0;
    if (edge_we) begin
      tag_we = 1'b1;
    end else if ((state == S_TUSE) && (item.cmd == CMD_INSERT) && (tag_rdata == '0)) begin
      tag_we    = 1'b1;
      tag_waddr = tag_addr;
      tag_wdata = item.tag;
    end
  end

  tdm_edge_mem #(.NODES(NODES)) u_edge (
    .clk   (clk),
    .we    (edge_we),
    .waddr (node_total[NB-1:0]),
    .wdata ({insert_cursor, item.symbol}),
    .re    (edge_re),
    .raddr (scan_n[NB-1:0]),
    .rdata (edge_rdata)
  );

  tdm_tag_mem #(.NODES(NODES)) u_tag (
    .clk   (clk),
    .rst   (rst),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr ((state == S_ILAST) ? insert_cursor : walk_cursor),
    .rdata (tag_rdata)
  );

  // Sequencer: dispatch, edge scan, tag lookup and result hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      walk_cursor   <= '0;
      insert_cursor <= '0;
      skip_rest     <= 1'b0;
      insert_fault  <= FAULT_NONE;
      node_total    <= CB'(1);
      pattern_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      // The emit state either reloads or holds the output register.
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          scan_n   <= CB'(1);
          tag_addr <= walk_cursor;
          if (item.cmd == CMD_RESET) begin
            walk_cursor <= '0;
            skip_rest   <= 1'b0;
            state       <= S_IDLE;
          end else if (item.cmd == CMD_INSERT) begin
            insert_fault <= fault_new;
            scan_parent  <= insert_cursor;
            if ((fault_new == FAULT_NONE) && !item.no_symbol) begin
              state <= S_SCAN;
            end else if (item.last) begin
              state <= S_ILAST;
            end else begin
              state <= S_IDLE;
            end
          end else if (skip_rest) begin
            if (item.last) begin
              skip_rest <= 1'b0;
            end
            state <= S_IDLE;
          end else begin
            scan_parent <= walk_cursor;
            if (item.cmd == CMD_EXACT) begin
              if (!item.no_symbol) begin
                state <= S_SCAN;
              end else if (item.last) begin
                state <= S_TUSE;
              end else begin
                state <= S_IDLE;
              end
            end else if (!item.no_symbol) begin
              state <= S_TUSE;
            end else if (item.last) begin
              emit_tag    <= '0;
              emit_status <= ST_MISS;
              state       <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          if (scan_n < node_total) begin
            state <= S_CMP;
          end else begin
            scan_found <= 1'b0;
            state      <= S_POST;
          end
        end
        S_CMP: begin
          if (edge_rdata == {scan_parent, item.symbol}) begin
            scan_found <= 1'b1;
            scan_node  <= scan_n[NB-1:0];
            state      <= S_POST;
          end else begin
            scan_n <= scan_n + CB'(1);
            state  <= S_SCAN;
          end
        end
        S_POST: begin
          tag_addr <= scan_node;
          if (item.cmd == CMD_INSERT) begin
            if (scan_found) begin
              insert_cursor <= scan_node;
            end else if (node_total >= CB'(NODES)) begin
              insert_fault <= FAULT_FULL;
            end else begin
              insert_cursor <= node_total[NB-1:0];
              node_total    <= node_total + CB'(1);
            end
            state <= item.last ? S_ILAST : S_IDLE;
          end else if (item.cmd == CMD_EXACT) begin
            if (!scan_found) begin
              walk_cursor <= '0;
              skip_rest   <= !item.last;
              emit_tag    <= '0;
              emit_status <= ST_MISS;
              state       <= S_EMIT;
            end else begin
              walk_cursor <= scan_node;
              if (item.last) begin
                state <= S_DISP;
                // Re-dispatch reads the tag of the new cursor as an empty last byte.
                item.no_symbol <= 1'b1;
              end else begin
                state <= S_IDLE;
              end
            end
          end else begin
            walk_cursor <= scan_found ? scan_node : '0;
            if (item.last) begin
              emit_tag    <= '0;
              emit_status <= ST_MISS;
              state       <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_ILAST: begin
          insert_cursor <= '0;
          insert_fault  <= FAULT_NONE;
          tag_addr      <= insert_cursor;
          emit_tag      <= '0;
          if (insert_fault == FAULT_ZERO) begin
            emit_status <= ST_ZERO;
            state       <= S_EMIT;
          end else if (insert_fault == FAULT_FULL) begin
            emit_status <= ST_FULL;
            state       <= S_EMIT;
          end else begin
            state <= S_TUSE;
          end
        end
        S_TUSE: begin
          if (item.cmd == CMD_INSERT) begin
            state <= S_EMIT;
            if (tag_rdata != '0) begin
              emit_tag    <= tag_rdata;
              emit_status <= ST_DUP;
            end else begin
              pattern_total <= pattern_total + COUNT_BITS'(1);
              emit_tag      <= item.tag;
              emit_status   <= ST_OK;
            end
          end else if (item.cmd == CMD_EXACT) begin
            state       <= S_EMIT;
            emit_tag    <= tag_rdata;
            emit_status <= (tag_rdata != '0) ? ST_OK : ST_MISS;
          end else if (tag_rdata != '0) begin
            state       <= S_EMIT;
            skip_rest   <= !item.last;
            emit_tag    <= tag_rdata;
            emit_status <= ST_OK;
          end else begin
            scan_n <= CB'(1);
            state  <= S_SCAN;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid                <= 1'b1;
            out_data.match_tag       <= emit_tag;
            out_data.status          <= emit_status;
            out_data.stored_patterns <= pattern_total;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/tdm_checker.sv
// Port-level checker for the trie dictionary matcher, bound to the top level.
// Depends on tdm_pkg and trie_dictionary_matcher_top.
module tdm_checker import tdm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // One beat at a time: the block is busy right after an accepted beat.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous beat in progress");

  // Failure results carry no tag.
  a_fail_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ST_MISS || out_data.status == ST_ZERO ||
                  out_data.status == ST_FULL) |-> out_data.match_tag == '0)
    else $error("failure result with nonzero tag");

  // Status stays within its defined codes.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_FULL)
    else $error("undefined status code");

endmodule

bind trie_dictionary_matcher_top tdm_checker u_tdm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### sim/tb.sv
// Self-checking testbench for trie_dictionary_matcher_top.
// Needs tdm_pkg and the matcher RTL. It runs a directed table, then random
// strings, then fills the node store to capacity and walks the full trie.
`timescale 1ns / 100ps

module tb;
  import tdm_pkg::*;

  localparam int NODE_CAP = NODES_DEFAULT;
  localparam int ITEM_GOAL = 1700;
  localparam int SETTLE_CYCLES = 3000;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Shadow copy of the trie and the cursors.
  logic [TAG_BITS-1:0]    trie_tag [NODE_CAP];
  int                     trie_parent [NODE_CAP];
  logic [SYMBOL_BITS-1:0] trie_label [NODE_CAP];
  int          node_count = 1;
  int          pattern_count = 0;
  int          walk_pos = 0;
  int          insert_pos = 0;
  bit          skip_string = 1'b0;
  logic [1:0]  insert_err = FAULT_NONE;

  out_beat_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int          beats_sent = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  bit          quiet_phase = 1'b0;
  int          stall_left = 0;
  logic [7:0]  sym_pool [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

  trie_dictionary_matcher_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Child of a node through a label, or NODE_CAP when absent.
  function automatic int child_of(input int node, input logic [SYMBOL_BITS-1:0] label);
    for (int n = 1; n < node_count; n++) begin
      if (trie_parent[n] == node && trie_label[n] == label) return n;
    end
    return NODE_CAP;
  endfunction

  function automatic out_beat_t make_result(input logic [TAG_BITS-1:0] t,
                                            input logic [2:0] st);
    out_beat_t r;
    r.match_tag = t;
    r.status = st;
    r.stored_patterns = pattern_count[COUNT_BITS-1:0];
    return r;
  endfunction

  // Advances the shadow trie by one beat; returns 1 when a result is due.
  function automatic bit trie_step(input in_beat_t b, output out_beat_t r);
    int nxt;
    int cur;
    logic [1:0] err;
    logic [TAG_BITS-1:0] t;
    r = '0;
    if (b.cmd == CMD_RESET) begin
      walk_pos = 0;
      skip_string = 1'b0;
      return 1'b0;
    end
    if (b.cmd == CMD_INSERT) begin
      if (insert_err == FAULT_NONE && b.tag == '0) insert_err = FAULT_ZERO;
      if (insert_err == FAULT_NONE && !b.no_symbol) begin
        nxt = child_of(insert_pos, b.symbol);
        if (nxt == NODE_CAP) begin
          if (node_count >= NODE_CAP) begin
            insert_err = FAULT_FULL;
          end else begin
            nxt = node_count;
            trie_parent[nxt] = insert_pos;
            trie_label[nxt] = b.symbol;
            trie_tag[nxt] = '0;
            node_count++;
          end
        end
        if (insert_err == FAULT_NONE) insert_pos = nxt;
      end
      if (!b.last) return 1'b0;
      err = insert_err;
      cur = insert_pos;
      insert_pos = 0;
      insert_err = FAULT_NONE;
      if (err == FAULT_ZERO) begin
        r = make_result('0, ST_ZERO);
      end else if (err == FAULT_FULL) begin
        r = make_result('0, ST_FULL);
      end else if (trie_tag[cur] != '0) begin
        r = make_result(trie_tag[cur], ST_DUP);
      end else begin
        trie_tag[cur] = b.tag;
        pattern_count++;
        r = make_result(b.tag, ST_OK);
      end
      return 1'b1;
    end
    if (skip_string) begin
      if (b.last) skip_string = 1'b0;
      return 1'b0;
    end
    cur = walk_pos;
    if (b.cmd == CMD_EXACT) begin
      if (!b.no_symbol) begin
        nxt = child_of(cur, b.symbol);
        if (nxt == NODE_CAP) begin
          walk_pos = 0;
          skip_string = !b.last;
          r = make_result('0, ST_MISS);
          return 1'b1;
        end
        walk_pos = nxt;
        cur = nxt;
      end
      if (!b.last) return 1'b0;
      t = trie_tag[cur];
      r = (t != '0) ? make_result(t, ST_OK) : make_result('0, ST_MISS);
      return 1'b1;
    end
    // Search reports the current node's tag before taking the byte.
    if (!b.no_symbol) begin
      t = trie_tag[cur];
      if (t != '0) begin
        skip_string = !b.last;
        r = make_result(t, ST_OK);
        return 1'b1;
      end
      nxt = child_of(cur, b.symbol);
      walk_pos = (nxt == NODE_CAP) ? 0 : nxt;
    end
    if (b.last) begin
      r = make_result('0, ST_MISS);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic in_beat_t mk_beat(input logic [1:0] c, input logic [7:0] s,
                                       input bit ns, input bit lst,
                                       input logic [15:0] t);
    in_beat_t b;
    b.cmd = c;
    b.symbol = s;
    b.no_symbol = ns;
    b.last = lst;
    b.tag = t;
    return b;
  endfunction

  function automatic void add_row(input in_beat_t b, input bit typed,
                                  input logic [15:0] t, input logic [2:0] st,
                                  input int cnt);
    stim_row_t row;
    row.beat = b;
    row.typed = typed;
    row.want.match_tag = t;
    row.want.status = st;
    row.want.stored_patterns = cnt[COUNT_BITS-1:0];
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, a few long ones, none during quiet phases.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one beat, waits for it to be taken, then predicts its result.
  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    int gap;
    out_beat_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    if (trie_step(b, r)) pending_results.push_back(typed ? want : r);
  endtask

  task automatic send(input in_beat_t b);
    send_beat(b, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    out_beat_t exp_r;
    int roll;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: tag %h status %0d count %0d",
                     out_data.match_tag, out_data.status, out_data.stored_patterns);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.match_tag !== exp_r.match_tag || out_data.status !== exp_r.status ||
              out_data.stored_patterns !== exp_r.stored_patterns) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected tag %h status %0d count %0d, got %h %0d %0d",
                       exp_r.match_tag, exp_r.status, exp_r.stored_patterns,
                       out_data.match_tag, out_data.status, out_data.stored_patterns);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 70) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        end
      end
    end
  end

  initial begin
    int kind;
    int len;
    logic [15:0] t;
    in_beat_t b;
    for (int n = 0; n < NODE_CAP; n++) begin
      trie_tag[n] = '0;
      trie_parent[n] = 0;
      trie_label[n] = '0;
    end

    // Directed table: typed results where they are obvious.
    add_row(mk_beat(CMD_EXACT, 8'h00, 1, 1, 16'h0001), 1, 16'h0, ST_MISS, 0);
    add_row(mk_beat(CMD_SEARCH, 8'h41, 0, 1, 16'h0001), 1, 16'h0, ST_MISS, 0);
    add_row(mk_beat(CMD_INSERT, 8'h00, 0, 1, 16'h0000), 1, 16'h0, ST_ZERO, 0);
    add_row(mk_beat(CMD_INSERT, 8'h00, 0, 0, 16'hFFFF), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_INSERT, 8'hFF, 0, 1, 16'hFFFF), 1, 16'hFFFF, ST_OK, 1);
    add_row(mk_beat(CMD_INSERT, 8'h00, 0, 0, 16'h0001), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_INSERT, 8'hFF, 0, 1, 16'h0001), 1, 16'hFFFF, ST_DUP, 1);
    add_row(mk_beat(CMD_RESET, 8'hFF, 1, 1, 16'hFFFF), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_EXACT, 8'h00, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_EXACT, 8'hFF, 0, 1, 16'h0000), 1, 16'hFFFF, ST_OK, 1);
    // A miss mid-string drops the rest of that string.
    add_row(mk_beat(CMD_EXACT, 8'h77, 0, 0, 16'h0000), 1, 16'h0, ST_MISS, 1);
    add_row(mk_beat(CMD_EXACT, 8'h00, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_EXACT, 8'h01, 0, 1, 16'h0000), 0, 0, ST_OK, 0);
    // Search hit on a deeper node skips the rest of the chunk.
    add_row(mk_beat(CMD_SEARCH, 8'h00, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_SEARCH, 8'hFF, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_SEARCH, 8'h12, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_SEARCH, 8'h34, 0, 1, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_SEARCH, 8'h00, 1, 1, 16'h0000), 1, 16'h0, ST_MISS, 1);
    // Zero tag in the middle of an insert; the first node stays.
    add_row(mk_beat(CMD_INSERT, 8'h5A, 0, 0, 16'h0005), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_INSERT, 8'hA5, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_INSERT, 8'h3C, 0, 1, 16'h0005), 1, 16'h0, ST_ZERO, 1);
    add_row(mk_beat(CMD_RESET, 8'h00, 0, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_EXACT, 8'h00, 1, 0, 16'h0000), 0, 0, ST_OK, 0);
    add_row(mk_beat(CMD_EXACT, 8'h5A, 0, 1, 16'h0000), 1, 16'h0, ST_MISS, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random strings over a small alphabet keep the trie shallow and dense.
    // Room is left for the fill phase so the whole run stays near the goal.
    while (beats_sent + (NODE_CAP - node_count) < ITEM_GOAL - 20) begin
      if (beats_sent % 150 == 0) quiet_phase = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        len = $urandom_range(1, 3);
        t = ($urandom_range(0, 19) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send(mk_beat(CMD_INSERT, 8'($urandom), 1, 0, t));
          send(mk_beat(CMD_INSERT, sym_pool[$urandom_range(0, 3)], 0, k == len - 1, t));
        end
      end else if (kind < 60) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          send(mk_beat(CMD_EXACT, sym_pool[$urandom_range(0, 3)],
                       $urandom_range(0, 11) == 0, k == len - 1, 16'($urandom)));
      end else if (kind < 90) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send(mk_beat(CMD_SEARCH, sym_pool[$urandom_range(0, 3)],
                       $urandom_range(0, 11) == 0, k == len - 1, 16'($urandom)));
      end else begin
        b = mk_beat(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 16'($urandom));
        send(b);
      end
    end
    drain_results();

    // Fill the node store with one long insert; it ends in a full fault.
    quiet_phase = 1'b1;
    send(mk_beat(CMD_INSERT, 8'hC3, 0, 0, 16'h0077));
    while (node_count < NODE_CAP)
      send(mk_beat(CMD_INSERT, 8'($urandom), 0, 0, 16'h0077));
    send(mk_beat(CMD_INSERT, 8'h81, 0, 0, 16'h0077));
    send(mk_beat(CMD_INSERT, 8'h7E, 0, 1, 16'h0077));
    quiet_phase = 1'b0;
    // Empty insert tags the root, then more inserts and a few walks on the full trie.
    send(mk_beat(CMD_INSERT, 8'h00, 1, 1, 16'h0007));
    send(mk_beat(CMD_INSERT, 8'h13, 0, 1, 16'h0009));
    send(mk_beat(CMD_INSERT, 8'h00, 0, 0, 16'h0009));
    send(mk_beat(CMD_INSERT, 8'hFF, 0, 1, 16'h0009));
    send(mk_beat(CMD_RESET, 8'h00, 0, 1, 16'h0000));
    send(mk_beat(CMD_SEARCH, 8'h00, 0, 1, 16'h0000));
    send(mk_beat(CMD_EXACT, 8'hC3, 0, 1, 16'h0000));
    send(mk_beat(CMD_EXACT, 8'h00, 1, 1, 16'h0000));
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d beats and checked %0d results; trie grew to %0d nodes, %0d patterns.",
             beats_sent, results_seen, node_count, pattern_count);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
